[sv/smpq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// smpq_pkg
// Shared types and constants for the sorted multiset priority queue.
// ----------------------------------------------------------------------------
package smpq_pkg;

   localparam int DATA_W  = 32;
   localparam int OP_W    = 2;
   localparam int ST_W    = 2;
   localparam int COUNT_W = 5;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
   localparam logic [OP_W-1:0] OP_POP    = 2'd2;

   localparam logic [ST_W-1:0] ST_DONE      = 2'd0;
   localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [ST_W-1:0] ST_EMPTY     = 2'd2;
   localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

   localparam logic signed [DATA_W-1:0] EMPTY_MARK = 32'sd9999999;

   // Per-cycle command broadcast to every cell
   typedef struct packed {
      logic cmp;       // compare stored entry with the item value
      logic ins;       // open a slot at the lower bound and write the value
      logic rem;       // close the slot at the lower bound
      logic rem_head;  // close the slot at the head
   } ctl_type;

endpackage
`default_nettype wire

[sv/smpq_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// smpq_req_if / smpq_rsp_if
// Valid/ready channels carrying request and response items.
// ----------------------------------------------------------------------------
interface smpq_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [smpq_pkg::OP_W-1:0]             opcode;
   logic signed [smpq_pkg::DATA_W-1:0]    item_value;

   modport source (output valid, output opcode, output item_value, input ready);
   modport sink   (input valid, input opcode, input item_value, output ready);
endinterface

interface smpq_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [smpq_pkg::ST_W-1:0]             status;
   logic signed [smpq_pkg::DATA_W-1:0]    popped_value;
   logic [smpq_pkg::COUNT_W-1:0]          entry_count;

   modport source (output valid, output status, output popped_value,
                   output entry_count, input ready);
   modport sink   (input valid, input status, input popped_value,
                   input entry_count, output ready);
endinterface
`default_nettype wire

[sv/smpq_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// smpq_cell
// One slot of the sorted chain: compares its entry with the item value and
// shifts towards either neighbour when the chain opens or closes a slot.
// ----------------------------------------------------------------------------
module smpq_cell (
   input  wire                                 clock,
   input  wire smpq_pkg::ctl_type              ctl,
   input  wire logic signed [smpq_pkg::DATA_W-1:0] value,
   input  wire                                 in_range,
   input  wire                                 lt_left,
   input  wire logic signed [smpq_pkg::DATA_W-1:0] data_left,
   input  wire logic signed [smpq_pkg::DATA_W-1:0] data_right,
   output logic signed [smpq_pkg::DATA_W-1:0]  data,
   output logic                                lt,
   output logic                                eq
);

   logic signed [smpq_pkg::DATA_W-1:0] data_ff, data_in;
   logic                               lt_ff, lt_in;
   logic                               eq_ff, eq_in;

   always_comb begin
      lt_in   = lt_ff;
      eq_in   = eq_ff;
      data_in = data_ff;
      if (ctl.cmp) begin
         lt_in = in_range && (data_ff < value);
         eq_in = in_range && (data_ff == value);
      end
      if (ctl.ins) begin
         if (!lt_left) begin
            data_in = data_left;
         end else if (!lt_ff) begin
            data_in = value;
         end
      end else if (ctl.rem_head || (ctl.rem && !lt_ff)) begin
         data_in = data_right;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      lt_ff   <= lt_in;
      eq_ff   <= eq_in;
   end

   assign data = data_ff;
   assign lt   = lt_ff;
   assign eq   = eq_ff;

endmodule
`default_nettype wire

[sv/sorted_multiset_priority_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_multiset_priority_queue
// Ascending store of signed values in a chain of cells; insert, delete one
// occurrence, or pop the smallest.
// ----------------------------------------------------------------------------
// Per request: the cells compare as the item is taken in S_IDLE, then the chain
// shifts in S_EXEC once the response register is free; the next request is only
// accepted after that commit. A new request is taken while a response waits.
// Reset clears the entry count and the handshake state; entries need none.
module sorted_multiset_priority_queue #(
   parameter int CAPACITY = 16
) (
   input  wire        clock,
   input  wire        reset,
   smpq_req_if.sink   req_ch,
   smpq_rsp_if.source rsp_ch
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic                                state_ff, state_in;
   logic [CNT_W-1:0]                    count_ff, count_in;
   logic [smpq_pkg::OP_W-1:0]           op_ff, op_in;
   logic signed [smpq_pkg::DATA_W-1:0]  value_ff, value_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [smpq_pkg::ST_W-1:0]           status_ff, status_in;
   logic signed [smpq_pkg::DATA_W-1:0]  popped_ff, popped_in;

   smpq_pkg::ctl_type                   ctl;
   logic signed [smpq_pkg::DATA_W-1:0]  cell_data [CAPACITY];
   logic [CAPACITY-1:0]                 cell_lt;
   logic [CAPACITY-1:0]                 cell_eq;
   logic [CAPACITY-1:0]                 in_range;

   logic req_fire;
   logic commit;
   logic full;
   logic found;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign commit   = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ch.ready);
   assign full     = (count_ff == CNT_W'(CAPACITY));
   assign found    = |cell_eq;

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         logic                               lt_left;
         logic signed [smpq_pkg::DATA_W-1:0] data_left;
         logic signed [smpq_pkg::DATA_W-1:0] data_right;

         assign in_range[gi] = (CNT_W'(gi) < count_ff);

         if (gi == 0) begin : g_head
            assign lt_left   = 1'b1;
            assign data_left = cell_data[gi];
         end else begin : g_body
            assign lt_left   = cell_lt[gi-1];
            assign data_left = cell_data[gi-1];
         end

         if (gi == CAPACITY - 1) begin : g_tail
            assign data_right = cell_data[gi];
         end else begin : g_next
            assign data_right = cell_data[gi+1];
         end

         smpq_cell u_cell (
            .clock      (clock),
            .ctl        (ctl),
            .value      (value_in),
            .in_range   (in_range[gi]),
            .lt_left    (lt_left),
            .data_left  (data_left),
            .data_right (data_right),
            .data       (cell_data[gi]),
            .lt         (cell_lt[gi]),
            .eq         (cell_eq[gi])
         );
      end
   endgenerate

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      op_in        = op_ff;
      value_in     = value_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      popped_in    = popped_ff;
      ctl          = '0;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in    = req_ch.opcode;
               value_in = req_ch.item_value;
               ctl.cmp  = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (commit) begin
               rsp_valid_in = 1'b1;
               status_in    = smpq_pkg::ST_DONE;
               popped_in    = '0;
               case (op_ff)
                  smpq_pkg::OP_INSERT: begin
                     if (full) begin
                        status_in = smpq_pkg::ST_FULL;
                     end else begin
                        ctl.ins  = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  smpq_pkg::OP_DELETE: begin
                     if (found) begin
                        ctl.rem  = 1'b1;
                        count_in = count_ff - 1'b1;
                     end else begin
                        status_in = smpq_pkg::ST_NOT_FOUND;
                     end
                  end
                  smpq_pkg::OP_POP: begin
                     if (count_ff == '0) begin
                        status_in = smpq_pkg::ST_EMPTY;
                        popped_in = smpq_pkg::EMPTY_MARK;
                     end else begin
                        popped_in    = cell_data[0];
                        ctl.rem_head = 1'b1;
                        count_in     = count_ff - 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff     <= op_in;
      value_ff  <= value_in;
      status_ff <= status_in;
      popped_ff <= popped_in;
   end

   assign req_ch.ready        = (state_ff == S_IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = status_ff;
   assign rsp_ch.popped_value = popped_ff;
   assign rsp_ch.entry_count  = smpq_pkg::COUNT_W'(count_ff);

endmodule
`default_nettype wire
